/* rtl/core/fsp2_pkg.sv */
// ----------------------------------------------------------------------------
// fsp2_pkg
// Shared types and constants for the binary64 power-of-two scaling core.
// ----------------------------------------------------------------------------
package fsp2_pkg;

  localparam int unsigned FracW = 52;
  localparam int unsigned ExpW  = 11;
  localparam int unsigned SigW  = 53;
  localparam int unsigned ScaleW = 32;
  localparam int unsigned NW    = 34;
  localparam int unsigned MaxShift = 54;
  localparam int unsigned ShW   = 6;
  localparam int unsigned LzW   = 6;

  localparam logic [ExpW-1:0] ExpOnes = '1;
  localparam logic [63:0] QuietBit = 64'h0008_0000_0000_0000;

  typedef enum logic [1:0] {
    KIND_PASS   = 2'd0,
    KIND_NORMAL = 2'd1,
    KIND_OVF    = 2'd2,
    KIND_TINY   = 2'd3
  } kind_e;

  // Stage 1 to stage 2: classified operand with normalized significand.
  typedef struct packed {
    logic            sign;
    logic            pass;
    logic [63:0]     pass_bits;
    logic            inv;
    logic [SigW-1:0] sig;
    logic [NW-1:0]   n;
  } s1_t;

  // Stage 2 to stage 3: result class and shift for the tiny path.
  typedef struct packed {
    logic            sign;
    kind_e           kind;
    logic [63:0]     pass_bits;
    logic            inv;
    logic [SigW-1:0] sig;
    logic [ExpW-1:0] ebits;
    logic [ShW-1:0]  sh;
  } s2_t;

  // Leading zero count of a 52-bit fraction, value 52 when empty.
  function automatic logic [LzW-1:0] lzc52(input logic [FracW-1:0] f);
    logic [LzW-1:0] c;
    logic           found;
    c = LzW'(FracW);
    found = 1'b0;
    for (int i = FracW - 1; i >= 0; i--) begin
      if (!found && f[i]) begin
        c = LzW'(FracW - 1 - i);
        found = 1'b1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/fp64_scale_by_power_of_two_core.sv */
// ----------------------------------------------------------------------------
// fp64_scale_by_power_of_two_core
// Binary64 ldexp: x times two to scale_exp, rounded once to nearest even.
// ----------------------------------------------------------------------------
// The core accepts one beat per clock while no stalled result holds the last
// stage, and returns the results in order. The three register stages are
// unpack and normalize with the exponent add, range classification,
// then denormalizing shift with rounding and packing. The whole pipeline
// advances whenever the last stage is empty or its result is being taken,
// so a stall on the output freezes every stage and nothing is lost.
module fp64_scale_by_power_of_two_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] x_bits_i,
  input  logic [31:0] scale_exp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_bits_o,
  output logic        overflow_flag_o,
  output logic        underflow_flag_o,
  output logic        inexact_flag_o,
  output logic        invalid_flag_o
);
  import fsp2_pkg::*;

  logic [2:0] vld_d, vld_q;
  logic adv;
  s1_t s1;
  s2_t s2;
  logic [3:0] flags;

  // A single advance signal keeps valid bits and data moving together.
  assign adv = !vld_q[2] || out_ready_i;
  assign in_ready_o = adv;
  assign vld_d = {vld_q[1], vld_q[0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  fsp2_unpack u_unpack (
    .clk_i, .en_i(adv), .x_bits_i, .scale_exp_i, .s1_o(s1)
  );

  fsp2_classify u_classify (
    .clk_i, .en_i(adv), .s1_i(s1), .s2_o(s2)
  );

  fsp2_round u_round (
    .clk_i, .en_i(adv), .s2_i(s2), .result_bits_o, .flags_o(flags)
  );

  assign out_valid_o      = vld_q[2];
  assign overflow_flag_o  = flags[3];
  assign underflow_flag_o = flags[2];
  assign inexact_flag_o   = flags[1];
  assign invalid_flag_o   = flags[0];

  // A stalled result must not move while the output waits.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_bits_o))
    else $error("result changed under stall");

  // Overflow always comes with inexact.
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_flag_o |-> inexact_flag_o && !underflow_flag_o)
    else $error("overflow without inexact");

  // An accepted beat reaches the output stage while the output keeps taking results.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_ready_i ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_o)
    else $error("beat lost in pipeline");

  // Invalid never combines with the arithmetic flags.
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_flag_o |-> !inexact_flag_o && !overflow_flag_o)
    else $error("invalid with arithmetic flags");
endmodule

/* rtl/core/fsp2_unpack.sv */
// ----------------------------------------------------------------------------
// fsp2_unpack
// Classifies the operand, normalizes subnormals and forms the exponent sum.
// ----------------------------------------------------------------------------
module fsp2_unpack (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [63:0]                 x_bits_i,
  input  logic [fsp2_pkg::ScaleW-1:0] scale_exp_i,
  output fsp2_pkg::s1_t               s1_o
);
  import fsp2_pkg::*;

  s1_t s1_d, s1_q;
  logic [ExpW-1:0]  efield;
  logic [FracW-1:0] frac;
  logic [LzW-1:0]   lz;
  logic [NW-1:0]    e;

  always_comb begin
    efield = x_bits_i[62:52];
    frac   = x_bits_i[51:0];
    lz     = lzc52(frac);
    s1_d.sign = x_bits_i[63];
    s1_d.pass = (efield == ExpOnes) || (x_bits_i[62:0] == '0);
    s1_d.inv  = (efield == ExpOnes) && (frac != '0) && !x_bits_i[51];
    s1_d.pass_bits = ((efield == ExpOnes) && (frac != '0)) ? (x_bits_i | QuietBit)
                                                           : x_bits_i;
    if (efield == '0) begin
      // Subnormal: shift the leading one up into the hidden position.
      s1_d.sig = {1'b0, frac} << (lz + LzW'(1));
      e = NW'(0) - NW'(lz);
    end else begin
      s1_d.sig = {1'b1, frac};
      e = NW'(efield);
    end
    s1_d.n = e + NW'(signed'(scale_exp_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;
endmodule

/* rtl/core/fsp2_classify.sv */
// ----------------------------------------------------------------------------
// fsp2_classify
// Decides overflow, normal or tiny result and the denormalizing shift.
// ----------------------------------------------------------------------------
module fsp2_classify (
  input  logic          clk_i,
  input  logic          en_i,
  input  fsp2_pkg::s1_t s1_i,
  output fsp2_pkg::s2_t s2_o
);
  import fsp2_pkg::*;

  s2_t s2_d, s2_q;
  logic signed [NW-1:0] n;
  logic [NW-1:0] sh_full;

  always_comb begin
    n = signed'(s1_i.n);
    sh_full = NW'(1) - s1_i.n;
    s2_d.sign = s1_i.sign;
    s2_d.pass_bits = s1_i.pass_bits;
    s2_d.inv = s1_i.inv;
    s2_d.sig = s1_i.sig;
    s2_d.ebits = s1_i.n[ExpW-1:0];
    s2_d.sh = ShW'(MaxShift);
    if (s1_i.pass) begin
      s2_d.kind = KIND_PASS;
    end else if (n >= signed'(NW'(ExpOnes))) begin
      s2_d.kind = KIND_OVF;
    end else if (n >= signed'(NW'(1))) begin
      s2_d.kind = KIND_NORMAL;
    end else begin
      s2_d.kind = KIND_TINY;
      if (sh_full < NW'(MaxShift)) begin
        s2_d.sh = sh_full[ShW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;
endmodule

/* rtl/core/fsp2_round.sv */
// ----------------------------------------------------------------------------
// fsp2_round
// Denormalizes with one round to nearest even and packs result and flags.
// ----------------------------------------------------------------------------
module fsp2_round (
  input  logic          clk_i,
  input  logic          en_i,
  input  fsp2_pkg::s2_t s2_i,
  output logic [63:0]   result_bits_o,
  output logic [3:0]    flags_o
);
  import fsp2_pkg::*;

  logic [63:0] res_d, res_q;
  logic [3:0]  flg_d, flg_q;
  logic [SigW+MaxShift-1:0] wide;
  logic [SigW-1:0] kept;
  logic [MaxShift-1:0] rem;
  logic [MaxShift-1:0] half;
  logic inx, up;

  always_comb begin
    wide = {s2_i.sig, {MaxShift{1'b0}}} >> s2_i.sh;
    kept = wide[SigW+MaxShift-1:MaxShift];
    rem  = wide[MaxShift-1:0];
    half = {1'b1, {(MaxShift-1){1'b0}}};
    inx  = rem != '0;
    up   = (rem > half) || ((rem == half) && kept[0]);
    res_d = s2_i.pass_bits;
    flg_d = {1'b0, 1'b0, 1'b0, s2_i.inv};  // ovf, unf, inx, inv
    case (s2_i.kind)
      KIND_PASS: begin
      end
      KIND_OVF: begin
        res_d = {s2_i.sign, ExpOnes, {FracW{1'b0}}};
        flg_d = 4'b1010;
      end
      KIND_NORMAL: begin
        res_d = {s2_i.sign, s2_i.ebits, s2_i.sig[FracW-1:0]};
        flg_d = 4'b0000;
      end
      KIND_TINY: begin
        res_d = {s2_i.sign, 63'(kept + SigW'(up))};
        flg_d = {1'b0, inx, inx, 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      flg_q <= flg_d;
    end
  end

  assign result_bits_o = res_q;
  assign flags_o = flg_q;
endmodule

/* dv/fp64_scale_by_power_of_two_core_tb.sv */
// ----------------------------------------------------------------------------
// fp64_scale_by_power_of_two_core_tb
// Self-checking bench for the binary64 ldexp core: directed corner operands,
// then random beats with bursty input and a stalling output, each result
// compared with an in-bench rounding predictor.
// ----------------------------------------------------------------------------
module fp64_scale_by_power_of_two_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One operand beat and one result beat.
  typedef struct packed {
    logic [63:0] x;
    logic [31:0] sc;
  } operand_t;

  typedef struct packed {
    logic [63:0] bits;
    logic        ovf;
    logic        unf;
    logic        inx;
    logic        inv;
  } scaled_t;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned RandomBeats = 1150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] x_bits_i = '0;
  logic [31:0] scale_exp_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] result_bits_o;
  logic        overflow_flag_o;
  logic        underflow_flag_o;
  logic        inexact_flag_o;
  logic        invalid_flag_o;

  operand_t pending_ops[$];
  scaled_t  expected_results[$];
  int       error_count = 0;
  bit       stim_done = 1'b0;
  // Test phase requests: the driver holds off, the output holds off.
  bit       drain_pause = 1'b0;
  int       hold_cycles = 0;

  always #10 clk_i = ~clk_i;

  fp64_scale_by_power_of_two_core DUT (.*);

  // Predicts x * 2^sc rounded once to nearest even, with the four flags.
  function automatic scaled_t scale_predict(operand_t op);
    scaled_t r;
    logic [10:0] ef;
    logic [51:0] fr;
    logic [52:0] sig;
    longint e, n, sh;
    logic [63:0] kept, rem, half, wide;
    r = '0;
    ef = op.x[62:52];
    fr = op.x[51:0];
    if (ef == fsp2_pkg::ExpOnes) begin
      // NaNs get quieted; a signaling NaN raises invalid. Infinity passes.
      r.bits = (fr != 0) ? (op.x | fsp2_pkg::QuietBit) : op.x;
      r.inv = (fr != 0) && !op.x[51];
      return r;
    end
    if (ef == 0 && fr == 0) begin
      r.bits = op.x;
      return r;
    end
    if (ef == 0) begin
      // Subnormal: shift until the hidden bit is set.
      sig = {1'b0, fr};
      e = 1;
      while (!sig[52]) begin
        sig = sig << 1;
        e--;
      end
    end else begin
      sig = {1'b1, fr};
      e = ef;
    end
    n = e + longint'($signed(op.sc));
    if (n >= 2047) begin
      r.bits = {op.x[63], 11'h7ff, 52'd0};
      r.ovf = 1'b1;
      r.inx = 1'b1;
    end else if (n >= 1) begin
      r.bits = {op.x[63], n[10:0], sig[51:0]};
    end else begin
      // Tiny: one denormalizing shift, capped where everything is sticky.
      sh = (1 - n > 54) ? 54 : 1 - n;
      wide = {11'd0, sig};
      kept = wide >> sh;
      rem = wide & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept++;
      r.bits = {op.x[63], 63'd0} | kept;
      r.inx = (rem != 0);
      r.unf = r.inx;
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Exponents mostly near the interesting window, sometimes anywhere.
  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 4400)) - 2200);
      default: return 32'($signed($urandom_range(0, 240)) - 120);
    endcase
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = rand64();
    case ($urandom_range(0, 9))
      0: v[62:52] = '0;                   // subnormal or zero
      1: v[62:52] = '1;                   // NaN or infinity
      2: v[62:0] = {11'd0, 52'd0};        // signed zero
      3: v[62:52] = 11'($urandom_range(1, 60));
      4: v[62:52] = 11'($urandom_range(1990, 2046));
      5: v[51:0] = 52'd1 << $urandom_range(0, 51);
      default: ;
    endcase
    return v;
  endfunction

  // Stimulus: directed corners, then random beats with test phases.
  initial begin
    operand_t op;
    pending_ops.push_back('{64'h7ff0_0000_0000_0001, 32'd5});      // signaling NaN
    pending_ops.push_back('{64'hfff8_0000_0000_0000, 32'd5});      // quiet NaN
    pending_ops.push_back('{64'hfff0_0000_0000_0000, 32'd100});    // -infinity
    pending_ops.push_back('{64'h8000_0000_0000_0000, 32'h7fff_ffff});
    pending_ops.push_back('{64'h0000_0000_0000_0000, 32'h8000_0000});
    pending_ops.push_back('{64'h7fef_ffff_ffff_ffff, 32'd1});      // overflow
    pending_ops.push_back('{64'hffef_ffff_ffff_ffff, 32'h7fff_ffff});
    pending_ops.push_back('{64'h3ff0_0000_0000_0000, 32'h8000_0000}); // deep underflow
    pending_ops.push_back('{64'h0000_0000_0000_0001, 32'd1074});   // subnormal to 1.0
    pending_ops.push_back('{64'h000f_ffff_ffff_ffff, 32'd1});      // subnormal up
    pending_ops.push_back('{64'h0010_0000_0000_0000, 32'hffff_ffff}); // exact tiny
    pending_ops.push_back('{64'h001f_ffff_ffff_ffff, 32'hffff_ffff}); // rounds to min normal
    pending_ops.push_back('{64'h3ff8_0000_0000_0000, -32'sd1075});  // three quarters of min sub, rounds up
    pending_ops.push_back('{64'h3ff0_0000_0000_0000, -32'sd1075});  // half of min sub
    pending_ops.push_back('{64'h3ff0_0000_0000_0001, -32'sd1075});  // above half
    pending_ops.push_back('{64'h3ff0_0000_0000_0000, -32'sd1076});  // shift 54
    pending_ops.push_back('{64'h3ff0_0000_0000_0000, 32'd1023});
    pending_ops.push_back('{64'h3ff0_0000_0000_0000, 32'd1024});
    pending_ops.push_back('{64'h8000_0000_0000_0001, 32'hffff_ffff});
    pending_ops.push_back('{64'hffff_ffff_ffff_ffff, 32'd0});
    pending_ops.push_back('{64'hbff0_0000_0000_0003, -32'sd1074});

    for (int i = 0; i < RandomBeats; i++) begin
      op.x = rand_operand();
      op.sc = rand_scale();
      // Every bit of both fields gets both values from plain random beats.
      if ($urandom_range(0, 15) == 0) begin
        op.x = rand64();
        op.sc = $urandom();
      end
      pending_ops.push_back(op);
      if (i == 300) begin
        // Long output stall while the input keeps offering beats.
        wait (pending_ops.size() < 200);
        hold_cycles = 200;
      end
      if (i == 700) begin
        wait (pending_ops.size() == 0);
        drain_pause = 1'b1;
        wait (!in_valid_i && expected_results.size() == 0);
        drain_pause = 1'b0;
      end
    end
    wait (pending_ops.size() == 0 && !in_valid_i);
    stim_done = 1'b1;
  end

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    operand_t op;
    if (in_valid_i && in_ready_o) begin
      expected_results.push_back(scale_predict('{x_bits_i, scale_exp_i}));
    end
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_ops.size() > 0 && !drain_pause) begin
        op = pending_ops.pop_front();
        in_valid_i <= 1'b1;
        x_bits_i <= op.x;
        scale_exp_i <= op.sc;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: output stall pattern and field-by-field comparison.
  int stall_phase = 0;
  always @(posedge clk_i) begin
    scaled_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation: bits=%h", result_bits_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_bits_o !== want.bits) begin
          $error("result_bits expected %h actual %h", want.bits, result_bits_o);
          error_count++;
        end
        if (overflow_flag_o !== want.ovf) begin
          $error("overflow_flag expected %b actual %b", want.ovf, overflow_flag_o);
          error_count++;
        end
        if (underflow_flag_o !== want.unf) begin
          $error("underflow_flag expected %b actual %b", want.unf, underflow_flag_o);
          error_count++;
        end
        if (inexact_flag_o !== want.inx) begin
          $error("inexact_flag expected %b actual %b", want.inx, inexact_flag_o);
          error_count++;
        end
        if (invalid_flag_o !== want.inv) begin
          $error("invalid_flag expected %b actual %b", want.inv, invalid_flag_o);
          error_count++;
        end
      end
    end
    stall_phase <= (stall_phase + 1) % 64;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else if (stall_phase < 24) begin
      // Stretch with the output always taken.
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog on cycles with neither an accepted input nor a taken result.
  int idle_count = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
    if (idle_count >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Reset, then wait for the pipeline to drain and report.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_results.size() == 0);
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* fp64_scale_by_power_of_two_core.f */
rtl/core/fsp2_pkg.sv
rtl/core/fsp2_unpack.sv
rtl/core/fsp2_classify.sv
rtl/core/fsp2_round.sv
rtl/core/fp64_scale_by_power_of_two_core.sv
dv/fp64_scale_by_power_of_two_core_tb.sv
